FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_HOLDS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/mwsm_pkg.sv
// ----------------------------------------------------------------------------
// mwsm_pkg
// Shared types, widths and helpers of the mecanum wheel speed mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsm_pkg;

	localparam int WHEELS      = 4;
	localparam int IN_W        = 16;
	localparam int WHEEL_W     = 18;
	localparam int PEAK_W      = 17;
	localparam int SPEED_W     = 15;
	localparam int ACCEL_W     = 8;
	localparam int DVD_W       = PEAK_W + SPEED_W;
	localparam int DIV_STEPS   = SPEED_W;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 80;
	localparam int QUEUE_DEPTH = 4;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = SPEED_W;

	localparam logic [CFG_ADDR_W-1:0] REG_MAX_RPM  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_LF   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_RF   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_LR   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_RR   = 3'd4;

	localparam logic [SPEED_W-1:0] MAX_RPM_RESET = 15'd3000;

	typedef logic [WHEELS-1:0][WHEEL_W-1:0] wheels_t;

	// one mixed command between front and back
	typedef struct packed {
		wheels_t              w;
		logic [PEAK_W-1:0]    peak;
		logic                 scale;
		logic [ACCEL_W-1:0]   accel;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [PEAK_W-1:0] wheel_mag(input logic [WHEEL_W-1:0] w);
		logic [WHEEL_W-1:0] n;
		n = w[WHEEL_W-1] ? (~w + 1'b1) : w;
		return n[PEAK_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/mwsm_queue.sv
// ----------------------------------------------------------------------------
// mwsm_queue
// Short command queue between the mixing front and the scaling back.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsm_queue #(
	parameter int DEPTH = mwsm_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire mwsm_pkg::cmd_t   wr_data,
	input  wire logic             pop,
	output mwsm_pkg::cmd_t        rd_data,
	output mwsm_pkg::q_stat_t     stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	mwsm_pkg::cmd_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign stat.full  = (cnt_q == FULL_CNT);
	assign stat.empty = (cnt_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/mwsm_front.sv
// ----------------------------------------------------------------------------
// mwsm_front
// Accepts items, mixes the four wheel speeds and flags those needing scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsm_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// forward_speed, strafe_speed, turn_speed, accel
	input  wire logic [mwsm_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  wire logic [mwsm_pkg::SPEED_W-1:0]          max_rpm,
	input  wire mwsm_pkg::q_stat_t                     q_stat,
	output logic                                       push,
	output mwsm_pkg::cmd_t                             cmd
);

	localparam int W = mwsm_pkg::WHEEL_W;
	localparam int I = mwsm_pkg::IN_W;

	logic                              vld_s1;
	mwsm_pkg::wheels_t                 w_s1;
	logic [mwsm_pkg::ACCEL_W-1:0]      accel_s1;
	logic                              adv;
	logic [W-1:0]                      f;
	logic [W-1:0]                      s;
	logic [W-1:0]                      t;
	mwsm_pkg::wheels_t                 mix;
	logic [mwsm_pkg::PEAK_W-1:0]       peak;
	logic [mwsm_pkg::PEAK_W-1:0]       mg;

	assign adv      = !vld_s1 || !q_stat.full;
	assign s_tready = adv;
	assign push     = vld_s1 && !q_stat.full;

	always_comb begin
		f = {{(W-I){s_tdata[I-1]}}, s_tdata[I-1:0]};
		s = {{(W-I){s_tdata[2*I-1]}}, s_tdata[2*I-1:I]};
		t = {{(W-I){s_tdata[3*I-1]}}, s_tdata[3*I-1:2*I]};
		mix[0] = f + s - t;
		mix[1] = f - s + t;
		mix[2] = f - s - t;
		mix[3] = f + s + t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			w_s1     <= mix;
			accel_s1 <= s_tdata[3*I +: mwsm_pkg::ACCEL_W];
		end
	end

	always_comb begin
		peak = '0;
		mg   = '0;
		for (int i = 0; i < mwsm_pkg::WHEELS; i++) begin
			mg = mwsm_pkg::wheel_mag(w_s1[i]);
			if (mg > peak) begin
				peak = mg;
			end
		end
		cmd.w     = w_s1;
		cmd.peak  = peak;
		cmd.scale = peak > {{(mwsm_pkg::PEAK_W-mwsm_pkg::SPEED_W){1'b0}}, max_rpm};
		cmd.accel = accel_s1;
	end

endmodule

`default_nettype wire

FILE: hdl/mwsm_back.sv
// ----------------------------------------------------------------------------
// mwsm_back
// Scales flagged wheels by max_rpm over the peak in a pipelined divider, then
// applies inversion, clamps and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsm_back (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire mwsm_pkg::q_stat_t                     q_stat,
	input  wire mwsm_pkg::cmd_t                        cmd,
	output logic                                       pop,
	input  wire logic [mwsm_pkg::SPEED_W-1:0]          max_rpm,
	input  wire logic [mwsm_pkg::WHEELS-1:0]           inv,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// per wheel {speed, reverse} LF, RF, LR, RR; accel_out; motion_active
	output logic [mwsm_pkg::OUT_TDATA_W-1:0]           m_tdata
);

	localparam int N  = mwsm_pkg::WHEELS;
	localparam int W  = mwsm_pkg::WHEEL_W;
	localparam int P  = mwsm_pkg::PEAK_W;
	localparam int Q  = mwsm_pkg::SPEED_W;
	localparam int D  = mwsm_pkg::DVD_W;
	localparam int K  = mwsm_pkg::DIV_STEPS;
	localparam int A  = mwsm_pkg::ACCEL_W;
	localparam int OW = mwsm_pkg::OUT_TDATA_W;

	typedef struct packed {
		logic [N-1:0][P-1:0]  rem;
		logic [N-1:0][Q-1:0]  dq;
		mwsm_pkg::wheels_t    w;
		logic [P-1:0]         peak;
		logic                 scale;
		logic [A-1:0]         accel;
	} div_item_t;

	function automatic div_item_t div_step(input div_item_t x);
		div_item_t  y;
		logic [P:0] r2;
		logic       b;
		y = x;
		for (int i = 0; i < N; i++) begin
			r2 = {x.rem[i], x.dq[i][Q-1]};
			if (r2 >= {1'b0, x.peak}) begin
				r2 = r2 - {1'b0, x.peak};
				b  = 1'b1;
			end else begin
				b  = 1'b0;
			end
			y.rem[i] = r2[P-1:0];
			y.dq[i]  = {x.dq[i][Q-2:0], b};
		end
		return y;
	endfunction

	div_item_t          div_s [K+1];
	logic               vld_s [K+1];
	div_item_t          first;
	logic [OW-1:0]      fin;
	logic [OW-1:0]      out_q;
	logic               out_vld_q;
	logic               adv;
	logic [D-1:0]       dvd;
	logic [W-1:0]       qx;
	logic [W-1:0]       wf;
	logic [W-1:0]       a;
	logic [P-1:0]       mg;
	logic [Q-1:0]       spd;
	logic               active;

	assign adv      = !out_vld_q || m_tready;
	assign pop      = adv && !q_stat.empty;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	always_comb begin
		first.w     = cmd.w;
		first.peak  = cmd.peak;
		first.scale = cmd.scale;
		first.accel = cmd.accel;
		dvd         = '0;
		for (int i = 0; i < N; i++) begin
			dvd = ({{(D-P){1'b0}}, mwsm_pkg::wheel_mag(cmd.w[i])} *
				{{(D-Q){1'b0}}, max_rpm}) + D'(cmd.peak >> 1);
			first.rem[i] = dvd[D-1:Q];
			first.dq[i]  = dvd[Q-1:0];
		end
	end

	always_comb begin
		div_item_t z;
		z      = div_s[K];
		fin    = '0;
		active = 1'b0;
		qx     = '0;
		wf     = '0;
		a      = '0;
		mg     = '0;
		spd    = '0;
		for (int i = 0; i < N; i++) begin
			qx = {{(W-Q){1'b0}}, z.dq[i]};
			if (z.scale) begin
				wf = z.w[i][W-1] ? (~qx + 1'b1) : qx;
			end else begin
				wf = z.w[i];
			end
			active = active || (wf != '0);
			a   = inv[i] ? (~wf + 1'b1) : wf;
			mg  = mwsm_pkg::wheel_mag(a);
			spd = (mg > {{(P-Q){1'b0}}, max_rpm}) ? max_rpm : mg[Q-1:0];
			fin[(Q+1)*i +: Q+1] = {spd, a[W-1]};
		end
		fin[(Q+1)*N +: A] = z.accel;
		fin[(Q+1)*N + A]  = active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= K; k++) begin
				vld_s[k] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= pop;
			for (int k = 1; k <= K; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			out_vld_q <= vld_s[K];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= first;
			for (int k = 1; k <= K; k++) begin
				div_s[k] <= div_step(div_s[k-1]);
			end
			out_q <= fin;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/mecanum_wheel_speed_mixer_unit.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer_unit
// Mixes forward, strafe and turn speeds into four mecanum wheel commands.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ stream (forward, strafe, turn speed and accel code)
//   and leave on the m_ stream as four direction/magnitude pairs, the accel
//   code and a motion flag. Registers are written through cfg_we, cfg_addr and
//   cfg_wdata; the user must do so only while no item is in flight, as the
//   block does not enforce it. Items pass one mixing stage, one queue slot,
//   one multiply stage, fifteen divider stages (one quotient bit each, four
//   wheel lanes side by side) and the output register. While m_tready is high,
//   throughput is one item per cycle; the divider pipeline sets the latency.
//   A stalled receiver freezes the back pipeline; the front keeps taking items
//   until the queue fills, then drops s_tready.
//   Reset empties the pipeline and queue, sets max_rpm to 3000 and clears all
//   inversion bits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mecanum_wheel_speed_mixer_unit #(
	parameter int QUEUE_DEPTH = mwsm_pkg::QUEUE_DEPTH
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// forward_speed[15:0], strafe_speed[31:16], turn_speed[47:32], accel[55:48]
	input  wire logic [mwsm_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// left_front_reverse[0], left_front_speed[15:1], right_front_reverse[16],
	// right_front_speed[31:17], left_rear_reverse[32], left_rear_speed[47:33],
	// right_rear_reverse[48], right_rear_speed[63:49], accel_out[71:64],
	// motion_active[72], zero fill [79:73]
	output logic [mwsm_pkg::OUT_TDATA_W-1:0]           m_tdata,
	input  wire logic                                  cfg_we,
	input  wire logic [mwsm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  wire logic [mwsm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	logic [mwsm_pkg::SPEED_W-1:0]   max_rpm_q;
	logic [mwsm_pkg::WHEELS-1:0]    inv_q;
	logic                           push;
	logic                           pop;
	mwsm_pkg::cmd_t                 wr_cmd;
	mwsm_pkg::cmd_t                 rd_cmd;
	mwsm_pkg::q_stat_t              q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rpm_q <= mwsm_pkg::MAX_RPM_RESET;
			inv_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				mwsm_pkg::REG_MAX_RPM: max_rpm_q <= cfg_wdata[mwsm_pkg::SPEED_W-1:0];
				mwsm_pkg::REG_INV_LF:  inv_q[0]  <= cfg_wdata[0];
				mwsm_pkg::REG_INV_RF:  inv_q[1]  <= cfg_wdata[0];
				mwsm_pkg::REG_INV_LR:  inv_q[2]  <= cfg_wdata[0];
				mwsm_pkg::REG_INV_RR:  inv_q[3]  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	mwsm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.max_rpm  (max_rpm_q),
		.q_stat   (q_stat),
		.push     (push),
		.cmd      (wr_cmd)
	);

	mwsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_cmd),
		.pop     (pop),
		.rd_data (rd_cmd),
		.stat    (q_stat)
	);

	mwsm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.cmd      (rd_cmd),
		.pop      (pop),
		.max_rpm  (max_rpm_q),
		.inv      (inv_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`ASSERT_IMPLIES(a_speed_cap, m_tvalid, (m_tdata[15:1] <= max_rpm_q) && (m_tdata[31:17] <= max_rpm_q) && (m_tdata[47:33] <= max_rpm_q) && (m_tdata[63:49] <= max_rpm_q), "wheel speed above max_rpm")
	`ASSERT_IMPLIES(a_still_zero, m_tvalid && !m_tdata[72], (m_tdata[15:1] == 15'd0) && (m_tdata[31:17] == 15'd0) && (m_tdata[47:33] == 15'd0) && (m_tdata[63:49] == 15'd0), "speed set without motion flag")
	`ASSERT_IMPLIES(a_zero_fwd, m_tvalid, !((m_tdata[15:1] == 15'd0) && m_tdata[0]) && !((m_tdata[31:17] == 15'd0) && m_tdata[16]) && !((m_tdata[47:33] == 15'd0) && m_tdata[32]) && !((m_tdata[63:49] == 15'd0) && m_tdata[48]), "reverse set on stopped wheel")
	`ASSERT_HOLDS(a_no_overrun, !(push && q_stat.full) && !(pop && q_stat.empty), "queue overrun or underrun")

endmodule

`default_nettype wire
